// File: rtl/dssb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dssb_pkg
// Shared types and constants of the DRRIP replacement core with stride
// based streaming bypass.
// ----------------------------------------------------------------------------
package dssb_pkg;

   localparam int             SEL_W      = 10;
   localparam logic [SEL_W-1:0] SEL_MID  = 10'd512;
   localparam logic [1:0]     RRPV_MAX   = 2'd3;
   localparam logic [1:0]     BRRIP_NEAR = 2'd2;
   localparam logic [1:0]     RRPV_HIT   = 2'd0;
   localparam logic [1:0]     REUSE_MAX  = 2'd3;
   localparam logic [1:0]     REUSE_FILL = 2'd1;
   localparam logic [1:0]     REUSE_STRONG = 2'd2;
   localparam int             MASK_W     = 16;
   localparam int             PADDR_W    = 64;
   localparam logic           CMD_VICTIM = 1'b0;
   localparam logic           CMD_UPDATE = 1'b1;

   typedef struct packed {
      logic              cmd;
      logic [10:0]       set_index;
      logic [3:0]        way_index;
      logic              was_hit;
      logic [63:0]       phys_address;
      logic [15:0]       valid_mask;
      logic [4:0]        random_draw;
   } req_type;

   typedef struct packed {
      logic [3:0]        victim_way;
      logic              streaming_seen;
      logic              bypassed;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_AGE,
      ST_DELTA,
      ST_BLOCK,
      ST_WRITE,
      ST_DONE
   } state_type;

   // sequencer to datapath
   typedef struct packed {
      logic clear_wr;
      logic req_ready;
      logic load;
      logic age;
      logic delta;
      logic delta_first;
      logic block;
      logic mem_wr;
      logic rsp_load;
   } ctrl_type;

   // datapath to sequencer
   typedef struct packed {
      logic req_valid;
      logic is_update;
      logic wraps;
      logic clear_last;
      logic step_last;
      logic rsp_free;
   } stat_type;

endpackage
`default_nettype wire

// File: rtl/drrip_ship_stream_bypass_replacement_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drrip_ship_stream_bypass_replacement_core
// DRRIP last-level cache replacement with reuse counters and a per-set
// stride detector that bypasses weak-reuse fills on streaming sets.
// ----------------------------------------------------------------------------
// One request is handled at a time. After reset the core sweeps its set
// store, one row per cycle, with req_ready low; csr writes are taken
// throughout. A request reads the whole set row once, works on it in a row
// register and writes it back: a victim request passes load, age, write
// and done, an update that does not wrap the history pointer passes load,
// block, write and done, and an update that wraps it runs the delta steps
// between load and block, where the shared 64-bit delta unit walks the
// history one entry per cycle. The result sits in an output register, so
// a stalled rsp side only holds the core once the next result is ready.
// ----------------------------------------------------------------------------
module drrip_ship_stream_bypass_replacement_core
   import dssb_pkg::*;
#(
   parameter int NUM_SETS     = 2048,
   parameter int NUM_WAYS     = 16,
   parameter int LEADER_COUNT = 64,
   parameter int HISTORY_LEN  = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire req_type          req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_type               rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [SEL_W-1:0] csr_data
);

   localparam int SET_W  = $clog2(NUM_SETS);
   localparam int WAY_W  = $clog2(NUM_WAYS);
   localparam int PTR_W  = $clog2(HISTORY_LEN);
   localparam int RR_W   = 2 * NUM_WAYS;
   localparam int HIST_W = PADDR_W * HISTORY_LEN;
   localparam int ROW_W  = 2 * RR_W + PTR_W + HIST_W;
   localparam int CMP_W  = 18;
   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(HISTORY_LEN - 1);
   localparam logic [SET_W-1:0] SET_LAST  = SET_W'(NUM_SETS - 1);
   localparam logic [CMP_W-1:0] SRRIP_END = CMP_W'(LEADER_COUNT);
   localparam logic [CMP_W-1:0] BRRIP_END = CMP_W'(2 * LEADER_COUNT);
   localparam logic [ROW_W-1:0] RESET_ROW =
      {{HIST_W{1'b0}}, {PTR_W{1'b0}}, {NUM_WAYS{REUSE_FILL}}, {NUM_WAYS{RRPV_MAX}}};

   // out-of-range set and way numbers wrap around
   function automatic logic [SET_W-1:0] reduce_set(input logic [10:0] s);
      logic [CMP_W-1:0] v;
      v = CMP_W'(s);
      for (int k = 0; k < 8; k++) begin
         if (v >= CMP_W'(NUM_SETS)) v = v - CMP_W'(NUM_SETS);
      end
      return v[SET_W-1:0];
   endfunction

   function automatic logic [WAY_W-1:0] reduce_way(input logic [3:0] w);
      logic [5:0] v;
      v = 6'(w);
      for (int k = 0; k < 8; k++) begin
         if (v >= 6'(NUM_WAYS)) v = v - 6'(NUM_WAYS);
      end
      return v[WAY_W-1:0];
   endfunction

   ctrl_type ctrl;
   stat_type stat;
   logic [PTR_W-1:0] step;
   logic             match;

   req_type                          req_ff, req_in;
   logic [SET_W-1:0]                 set_ff, set_in;
   logic [WAY_W-1:0]                 way_ff, way_in;
   logic [NUM_WAYS-1:0][1:0]         rrpv_ff, rrpv_in;
   logic [NUM_WAYS-1:0][1:0]         reuse_ff, reuse_in;
   logic [HISTORY_LEN-1:0][PADDR_W-1:0] hist_ff, hist_in;
   logic [PTR_W-1:0]                 ptr_ff, ptr_in;
   logic                             wrap_ff, wrap_in;
   logic [1:0]                       max_ff, max_in;
   logic [WAY_W-1:0]                 vict_ff, vict_in;
   logic                             stream_ff, stream_in;
   logic                             bypass_ff, bypass_in;
   logic [SET_W-1:0]                 clr_ff, clr_in;
   logic [SEL_W-1:0]                 sel_ff, sel_in;
   rsp_type                          rsp_ff, rsp_in;
   logic                             rsp_valid_ff, rsp_valid_in;

   logic [ROW_W-1:0]                 rd_row;
   logic [NUM_WAYS-1:0][1:0]         m_rrpv;
   logic [NUM_WAYS-1:0][1:0]         m_reuse;
   logic [PTR_W-1:0]                 m_ptr;
   logic [HISTORY_LEN-1:0][PADDR_W-1:0] m_hist;
   logic                             mem_wr_en;
   logic [SET_W-1:0]                 mem_wr_addr;
   logic [ROW_W-1:0]                 mem_wr_data;
   logic                             accept;

   logic [NUM_WAYS-1:0][1:0]         aged;
   logic [NUM_WAYS-1:0]              rr_hi, rr_lo;
   logic                             inv_found;
   logic [WAY_W-1:0]                 inv_way;
   logic [WAY_W-1:0]                 top_way;
   logic [1:0]                       reuse_dec;
   logic [1:0]                       ins;
   logic                             bimodal;
   logic                             stream_now;
   logic [CMP_W-1:0]                 set_wide;
   logic [4:0]                       vict_wide;

   assign accept = req_valid & ctrl.req_ready;

   // ---------------------------------------------------------------- storage
   dssb_row_mem #(
      .DATA_W (ROW_W),
      .DEPTH  (NUM_SETS),
      .ADDR_W (SET_W)
   ) u_row_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (accept),
      .rd_addr (reduce_set(req_data.set_index)),
      .rd_data (rd_row)
   );

   assign mem_wr_en   = ctrl.clear_wr | ctrl.mem_wr;
   assign mem_wr_addr = ctrl.clear_wr ? clr_ff : set_ff;
   assign mem_wr_data = ctrl.clear_wr ? RESET_ROW : {hist_ff, ptr_ff, reuse_ff, rrpv_ff};

   assign m_rrpv  = rd_row[RR_W-1:0];
   assign m_reuse = rd_row[2*RR_W-1:RR_W];
   assign m_ptr   = rd_row[2*RR_W+PTR_W-1:2*RR_W];
   assign m_hist  = rd_row[ROW_W-1:2*RR_W+PTR_W];

   // ------------------------------------------------------------- sequencer
   dssb_seq #(
      .STEP_W (PTR_W)
   ) u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl),
      .step  (step)
   );

   always_comb begin
      stat            = '0;
      stat.req_valid  = req_valid;
      stat.is_update  = (req_ff.cmd == CMD_UPDATE);
      stat.wraps      = (m_ptr == PTR_LAST);
      stat.clear_last = (clr_ff == SET_LAST);
      stat.step_last  = (step == PTR_LAST);
      stat.rsp_free   = ~rsp_valid_ff | rsp_ready;
   end

   // shared delta unit walks consecutive history entries
   dssb_delta u_delta (
      .clock (clock),
      .en    (ctrl.delta),
      .first (ctrl.delta_first),
      .newer (hist_ff[step]),
      .older (hist_ff[step - PTR_W'(1)]),
      .match (match)
   );

   // ------------------------------------------------------- victim search
   always_comb begin
      for (int w = 0; w < NUM_WAYS; w++) begin
         rr_hi[w] = m_rrpv[w][1];
         rr_lo[w] = m_rrpv[w][0];
      end
   end

   // maximum of 2-bit values by reduction
   always_comb begin
      if (|(rr_hi & rr_lo)) max_in = 2'd3;
      else if (|rr_hi)      max_in = 2'd2;
      else if (|rr_lo)      max_in = 2'd1;
      else                  max_in = 2'd0;
      if (!ctrl.load) max_in = max_ff;
   end

   always_comb begin
      for (int w = 0; w < NUM_WAYS; w++) begin
         aged[w] = rrpv_ff[w] + (RRPV_MAX - max_ff);
      end
   end

   // lowest invalid way, ways beyond the mask count as valid
   always_comb begin
      inv_found = 1'b0;
      inv_way   = '0;
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (w < MASK_W) begin
            if (!req_ff.valid_mask[w]) begin
               inv_found = 1'b1;
               inv_way   = WAY_W'(w);
            end
         end
      end
   end

   always_comb begin
      top_way = '0;
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (aged[w] == RRPV_MAX) top_way = WAY_W'(w);
      end
   end

   // --------------------------------------------------------- block update
   assign set_wide   = CMP_W'(set_ff);
   assign stream_now = wrap_ff & match;

   always_comb begin
      reuse_dec = (reuse_ff[way_ff] != 2'd0) ? reuse_ff[way_ff] - 2'd1 : 2'd0;
      if (set_wide < SRRIP_END)      bimodal = 1'b0;
      else if (set_wide < BRRIP_END) bimodal = 1'b1;
      else                           bimodal = (sel_ff < SEL_MID);
      ins = BRRIP_NEAR;
      if (bimodal) ins = (req_ff.random_draw == 5'd0) ? BRRIP_NEAR : RRPV_MAX;
      if (reuse_dec >= REUSE_STRONG) ins = RRPV_HIT;
      if (stream_now && (reuse_dec < REUSE_STRONG)) ins = RRPV_MAX;
   end

   // ------------------------------------------------------- row register
   always_comb begin
      req_in    = req_ff;
      set_in    = set_ff;
      way_in    = way_ff;
      rrpv_in   = rrpv_ff;
      reuse_in  = reuse_ff;
      hist_in   = hist_ff;
      ptr_in    = ptr_ff;
      wrap_in   = wrap_ff;
      vict_in   = vict_ff;
      stream_in = stream_ff;
      bypass_in = bypass_ff;

      if (accept) begin
         req_in = req_data;
         set_in = reduce_set(req_data.set_index);
         way_in = reduce_way(req_data.way_index);
      end

      if (ctrl.load) begin
         rrpv_in   = m_rrpv;
         reuse_in  = m_reuse;
         hist_in   = m_hist;
         ptr_in    = m_ptr;
         wrap_in   = 1'b0;
         vict_in   = '0;
         stream_in = 1'b0;
         bypass_in = 1'b0;
         if (req_ff.cmd == CMD_UPDATE) begin
            hist_in[m_ptr] = req_ff.phys_address;
            ptr_in         = (m_ptr == PTR_LAST) ? '0 : m_ptr + PTR_W'(1);
            wrap_in        = (m_ptr == PTR_LAST);
         end
      end

      if (ctrl.age) begin
         if (inv_found) begin
            vict_in = inv_way;
         end else begin
            vict_in = top_way;
            rrpv_in = aged;
         end
      end

      if (ctrl.block) begin
         stream_in = stream_now;
         if (req_ff.was_hit) begin
            rrpv_in[way_ff]  = RRPV_HIT;
            reuse_in[way_ff] = (reuse_ff[way_ff] != REUSE_MAX) ?
                               reuse_ff[way_ff] + 2'd1 : REUSE_MAX;
         end else begin
            rrpv_in[way_ff]  = ins;
            reuse_in[way_ff] = REUSE_FILL;
            bypass_in        = stream_now && (reuse_dec < REUSE_STRONG);
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      set_ff    <= set_in;
      way_ff    <= way_in;
      rrpv_ff   <= rrpv_in;
      reuse_ff  <= reuse_in;
      hist_ff   <= hist_in;
      ptr_ff    <= ptr_in;
      wrap_ff   <= wrap_in;
      max_ff    <= max_in;
      vict_ff   <= vict_in;
      stream_ff <= stream_in;
      bypass_ff <= bypass_in;
   end

   // ------------------------------------------------ clear sweep, csr, rsp
   assign clr_in    = ctrl.clear_wr ? clr_ff + SET_W'(1) : clr_ff;
   assign sel_in    = csr_valid ? csr_data : sel_ff;
   assign csr_ready = 1'b1;

   assign vict_wide = 5'(vict_ff);

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (ctrl.rsp_load) begin
         rsp_in.victim_way     = vict_wide[3:0];
         rsp_in.streaming_seen = stream_ff;
         rsp_in.bypassed       = bypass_ff;
         rsp_valid_in          = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         sel_ff       <= SEL_MID;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign req_ready = ctrl.req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// File: rtl/dssb_row_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dssb_row_mem
// Per-set row store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dssb_row_mem #(
   parameter int DATA_W = 322,
   parameter int DEPTH  = 2048,
   parameter int ADDR_W = 11
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: rtl/dssb_delta.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dssb_delta
// Shared 64-bit subtract and compare unit of the stride detector. The first
// step stores the reference delta, later steps check against it.
// ----------------------------------------------------------------------------
module dssb_delta
   import dssb_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic               first,
   input  wire logic [PADDR_W-1:0] newer,
   input  wire logic [PADDR_W-1:0] older,
   output logic                    match
);

   logic [PADDR_W-1:0] diff;
   logic [PADDR_W-1:0] ref_ff, ref_in;
   logic               match_ff, match_in;

   assign diff = newer - older;

   always_comb begin
      ref_in   = ref_ff;
      match_in = match_ff;
      if (en) begin
         if (first) begin
            ref_in   = diff;
            match_in = 1'b1;
         end else begin
            match_in = match_ff & (diff == ref_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      ref_ff   <= ref_in;
      match_ff <= match_in;
   end

   assign match = match_ff;

endmodule
`default_nettype wire

// File: rtl/dssb_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dssb_seq
// Sequencer: clearing pass, row load, aging or stride steps, block update,
// write back and result hand-off.
// ----------------------------------------------------------------------------
module dssb_seq
   import dssb_pkg::*;
#(
   parameter int STEP_W = 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire stat_type          stat,
   output ctrl_type               ctrl,
   output logic      [STEP_W-1:0] step
);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (stat.clear_last) state_in = ST_IDLE;
         ST_IDLE:  if (stat.req_valid) state_in = ST_LOAD;
         ST_LOAD: begin
            if (!stat.is_update) state_in = ST_AGE;
            else if (stat.wraps) state_in = ST_DELTA;
            else                 state_in = ST_BLOCK;
         end
         ST_AGE:   state_in = ST_WRITE;
         ST_DELTA: if (stat.step_last) state_in = ST_BLOCK;
         ST_BLOCK: state_in = ST_WRITE;
         ST_WRITE: state_in = ST_DONE;
         ST_DONE:  if (stat.rsp_free) state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      ctrl             = '0;
      ctrl.delta_first = (step_ff == STEP_W'(1));
      unique case (state_ff)
         ST_CLEAR: ctrl.clear_wr  = 1'b1;
         ST_IDLE:  ctrl.req_ready = 1'b1;
         ST_LOAD:  ctrl.load      = 1'b1;
         ST_AGE:   ctrl.age       = 1'b1;
         ST_DELTA: ctrl.delta     = 1'b1;
         ST_BLOCK: ctrl.block     = 1'b1;
         ST_WRITE: ctrl.mem_wr    = 1'b1;
         ST_DONE:  ctrl.rsp_load  = stat.rsp_free;
         default:  ctrl           = '0;
      endcase
   end

   // step walks the history from entry 1 to the last one
   always_comb begin
      step_in = step_ff;
      if (state_ff == ST_LOAD) begin
         step_in = STEP_W'(1);
      end else if (state_ff == ST_DELTA) begin
         step_in = step_ff + STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   assign step = step_ff;

endmodule
`default_nettype wire
